[rtl/pab_pkg.sv]
// ============================================================================
// pab_pkg : shared types and constants for the prioritised alarm beeper
// Field layout of the stream words, register codes, filter arithmetic
// constants and the request and configuration structs.
// ============================================================================
package pab_pkg;

    // ------------------------------------------------------------------
    // Battery filter fixed point
    // ------------------------------------------------------------------
    localparam int FILT_FRAC_BITS = 16;
    localparam int MV_W           = 16;
    localparam int FILT_W         = MV_W + FILT_FRAC_BITS;

    // f' = f + floor((x + 50 - f) / 100). The difference is lifted by
    // 100*K so that it stays non-negative, then divided by 4 (shift) and
    // by 25 (reciprocal multiply); K is taken off again afterwards.
    localparam longint FILT_OFS_K_L    = ((64'd1 << FILT_W) + 64'd99) / 64'd100;
    localparam longint FILT_OFS_100K_L = FILT_OFS_K_L * 64'd100;
    localparam int     DIVQ_W       = FILT_W - 1;            // dividend after >> 2
    localparam int     DIV25_SH     = DIVQ_W + 5;
    localparam int     DIV25_MUL_W  = DIVQ_W + 1;
    localparam longint DIV25_MUL_L  = ((64'd1 << DIV25_SH) + 64'd24) / 64'd25;
    localparam int     PROD_W       = DIVQ_W + DIV25_MUL_W;
    localparam int     QUOT_W       = PROD_W - DIV25_SH;

    localparam logic [FILT_W:0]        FILT_OFS_K    = (FILT_W+1)'(FILT_OFS_K_L);
    localparam logic [FILT_W:0]        FILT_OFS_100K = (FILT_W+1)'(FILT_OFS_100K_L);
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL   = DIV25_MUL_W'(DIV25_MUL_L);
    localparam logic [FILT_W:0]        FILT_ROUND  = (FILT_W+1)'(50);
    localparam logic [FILT_W-1:0]      FILT_RESET  = FILT_W'(20000) << FILT_FRAC_BITS;

    // ------------------------------------------------------------------
    // Tones in Hz; the high tones are the base tone times 1.122462,
    // truncated
    // ------------------------------------------------------------------
    localparam int TONE_W = 12;
    localparam logic [TONE_W-1:0] TONE_ERROR   = 12'd2200;
    localparam logic [TONE_W-1:0] TONE_LINK_LO = 12'd500;
    localparam logic [TONE_W-1:0] TONE_LINK_HI = 12'd561;
    localparam logic [TONE_W-1:0] TONE_VIS_LO  = 12'd2000;
    localparam logic [TONE_W-1:0] TONE_VIS_HI  = 12'd2244;

    localparam int TICK_W   = 8;
    localparam int MODE_W   = 4;
    localparam int PERIOD_W = 8;

    // ------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ALM_NONE   = 3'd0,
        ALM_ERROR  = 3'd1,
        ALM_LOW_V  = 3'd2,
        ALM_LINK   = 3'd3,
        ALM_VISION = 3'd4
    } t_alarm;

    typedef enum logic [2:0] {
        REG_LV_LIMIT   = 3'd0,
        REG_DBG_LIMIT  = 3'd1,
        REG_VIS_FRESH  = 3'd2,
        REG_ERR_PERIOD = 3'd3,
        REG_LV_PERIOD  = 3'd4,
        REG_LNK_PERIOD = 3'd5,
        REG_VIS_PERIOD = 3'd6
    } t_reg_idx;

    // ------------------------------------------------------------------
    // Stream word layout
    // ------------------------------------------------------------------
    localparam int S_TDATA_W = 40;
    localparam int S_ERR_LSB  = 0;
    localparam int S_MV_LSB   = 1;
    localparam int S_LINK_LSB = 17;
    localparam int S_MODE_LSB = 18;
    localparam int S_CONN_LSB = 22;
    localparam int S_AGE_LSB  = 23;

    localparam int M_TDATA_W  = 40;
    localparam int M_ACT_LSB  = 0;
    localparam int M_TONE_LSB = 2;
    localparam int M_ALM_LSB  = 14;
    localparam int M_BEEP_LSB = 17;
    localparam int M_FMV_LSB  = 18;
    localparam int M_USED_W   = 34;

    // APB
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Structs
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                err;
        logic                link;
        logic [MODE_W-1:0]   mode;
        logic                conn;
        logic [MV_W-1:0]     age;
        logic [FILT_W-1:0]   filt;
    } t_item;

    typedef struct packed {
        logic [MV_W-1:0]     lv_limit;
        logic [MODE_W-1:0]   dbg_limit;
        logic [MV_W-1:0]     vis_fresh;
        logic [PERIOD_W-1:0] err_period;
        logic [PERIOD_W-1:0] lv_period;
        logic [PERIOD_W-1:0] lnk_period;
        logic [PERIOD_W-1:0] vis_period;
    } t_cfg;

endpackage

[rtl/pab_front.sv]
// ============================================================================
// pab_front : request intake and battery filter
// Takes status requests, updates the battery EMA once per request while no
// error is flagged, and pushes the request with the new filter value.
// ============================================================================
module pab_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pab_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_full,
    output logic                          o_push,
    output pab_pkg::t_item                o_item
);

    logic [pab_pkg::FILT_W-1:0]      r_filt;
    logic [pab_pkg::FILT_W-1:0]      n_filt;
    logic [pab_pkg::FILT_W:0]        lifted;
    logic [pab_pkg::DIVQ_W-1:0]      quarter;
    logic [pab_pkg::PROD_W-1:0]      prod;
    logic [pab_pkg::QUOT_W-1:0]      quot;
    logic [pab_pkg::FILT_W:0]        upd;
    logic [pab_pkg::MV_W-1:0]        mv;
    logic                            err;
    logic                            accept;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;
    assign o_push     = accept;

    assign err = i_s_tdata[pab_pkg::S_ERR_LSB];
    assign mv  = i_s_tdata[pab_pkg::S_MV_LSB +: pab_pkg::MV_W];

    // EMA step: f + floor((x + 50 - f) / 100), done as (.. + 100K) >> 2, / 25
    always_comb begin
        lifted  = {1'b0, mv, {pab_pkg::FILT_FRAC_BITS{1'b0}}} + pab_pkg::FILT_ROUND
                + pab_pkg::FILT_OFS_100K - {1'b0, r_filt};
        quarter = lifted[pab_pkg::FILT_W:2];
        prod    = pab_pkg::PROD_W'(quarter) * pab_pkg::PROD_W'(pab_pkg::DIV25_MUL);
        quot    = prod[pab_pkg::PROD_W-1:pab_pkg::DIV25_SH];
        upd     = {1'b0, r_filt} + (pab_pkg::FILT_W+1)'(quot) - pab_pkg::FILT_OFS_K;
        n_filt  = err ? r_filt : upd[pab_pkg::FILT_W-1:0];
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= pab_pkg::FILT_RESET;
        end else if (accept) begin
            r_filt <= n_filt;
        end
    end

    // request to the queue
    always_comb begin
        o_item.err  = err;
        o_item.link = i_s_tdata[pab_pkg::S_LINK_LSB];
        o_item.mode = i_s_tdata[pab_pkg::S_MODE_LSB +: pab_pkg::MODE_W];
        o_item.conn = i_s_tdata[pab_pkg::S_CONN_LSB];
        o_item.age  = i_s_tdata[pab_pkg::S_AGE_LSB +: pab_pkg::MV_W];
        o_item.filt = n_filt;
    end

endmodule

[rtl/pab_queue.sv]
// ============================================================================
// pab_queue : short request queue
// Two-entry FIFO between the filter front and the alarm back end.
// ============================================================================
module pab_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pab_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pab_pkg::t_item  o_item
);

    pab_pkg::t_item               r_mem [pab_pkg::QUEUE_DEPTH];
    logic [pab_pkg::QPTR_W-1:0]   r_wp;
    logic [pab_pkg::QPTR_W-1:0]   r_rp;
    logic [pab_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == pab_pkg::QCNT_W'(pab_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == pab_pkg::QPTR_W'(pab_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == pab_pkg::QPTR_W'(pab_pkg::QUEUE_DEPTH - 1))
                      ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[rtl/pab_back.sv]
// ============================================================================
// pab_back : alarm selection and beep sequencer
// Picks the highest active alarm, runs the tick counter and beep phase, and
// holds each result in an output register until it is taken.
// ============================================================================
module pab_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pab_pkg::t_cfg                 i_cfg,
    input  logic                          i_empty,
    input  pab_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pab_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // sequencer state
    logic [pab_pkg::TICK_W-1:0]   r_tick,  n_tick;
    logic                         r_phase, n_phase;
    logic                         r_high,  n_high;
    logic                         r_seen,  n_seen;

    // result register
    logic                         r_valid;
    pab_pkg::t_action             r_action, n_action;
    logic [pab_pkg::TONE_W-1:0]   r_tone,   n_tone;
    pab_pkg::t_alarm              r_alarm,  n_alarm;
    logic [pab_pkg::MV_W-1:0]     r_fmv;

    logic [pab_pkg::TICK_W-1:0]   tick_inc;
    logic [pab_pkg::PERIOD_W-1:0] period;
    logic [pab_pkg::MV_W-1:0]     f_int;
    logic                         low_hit;
    logic                         link_hit;
    logic                         mode_ok;
    logic                         fresh;
    logic                         vis_hit;

    assign o_pop = !i_empty && (!r_valid || i_m_tready);

    // alarm conditions and beep sequencing
    always_comb begin
        tick_inc = (r_tick == '1) ? r_tick : r_tick + 1'b1;
        f_int    = i_item.filt[pab_pkg::FILT_W-1:pab_pkg::FILT_FRAC_BITS];
        low_hit  = (i_item.filt != '0) && (f_int < i_cfg.lv_limit);
        mode_ok  = (i_item.mode <= i_cfg.dbg_limit);
        link_hit = i_item.link && mode_ok;
        fresh    = i_item.conn && (i_item.age < i_cfg.vis_fresh);
        vis_hit  = i_item.conn && !fresh && mode_ok && r_seen;

        n_tick   = tick_inc;
        n_phase  = r_phase;
        n_high   = r_high;
        n_seen   = r_seen;
        n_action = pab_pkg::ACT_NONE;
        n_tone   = '0;

        // priority order; the vision latch only sees requests no higher alarm took
        if (i_item.err) begin
            n_alarm = pab_pkg::ALM_ERROR;
            period  = i_cfg.err_period;
        end else if (low_hit) begin
            n_alarm = pab_pkg::ALM_LOW_V;
            period  = i_cfg.lv_period;
        end else if (link_hit) begin
            n_alarm = pab_pkg::ALM_LINK;
            period  = i_cfg.lnk_period;
        end else begin
            n_seen  = r_seen || fresh;
            n_alarm = vis_hit ? pab_pkg::ALM_VISION : pab_pkg::ALM_NONE;
            period  = i_cfg.vis_period;
        end

        if (n_alarm == pab_pkg::ALM_NONE) begin
            if (r_phase) begin
                n_phase  = 1'b0;
                n_action = pab_pkg::ACT_STOP;
            end
        end else if (tick_inc > period) begin
            n_tick = '0;
            if (!r_phase) begin
                n_phase = 1'b1;
                // low voltage toggles silently
                case (n_alarm)
                    pab_pkg::ALM_ERROR: begin
                        n_action = pab_pkg::ACT_START;
                        n_tone   = pab_pkg::TONE_ERROR;
                    end
                    pab_pkg::ALM_LINK: begin
                        n_action = pab_pkg::ACT_START;
                        n_tone   = r_high ? pab_pkg::TONE_LINK_HI : pab_pkg::TONE_LINK_LO;
                        n_high   = !r_high;
                    end
                    pab_pkg::ALM_VISION: begin
                        n_action = pab_pkg::ACT_START;
                        n_tone   = r_high ? pab_pkg::TONE_VIS_HI : pab_pkg::TONE_VIS_LO;
                        n_high   = !r_high;
                    end
                    default: begin
                        n_action = pab_pkg::ACT_NONE;
                    end
                endcase
            end else begin
                n_phase  = 1'b0;
                n_action = pab_pkg::ACT_STOP;
            end
        end
    end

    // state and valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_phase <= 1'b0;
            r_high  <= 1'b0;
            r_seen  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_tick  <= n_tick;
                r_phase <= n_phase;
                r_high  <= n_high;
                r_seen  <= n_seen;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= n_action;
            r_tone   <= n_tone;
            r_alarm  <= n_alarm;
            r_fmv    <= f_int;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(pab_pkg::M_TDATA_W - pab_pkg::M_USED_W){1'b0}},
                         r_fmv, r_phase, r_alarm, r_tone, r_action};

endmodule

[rtl/prioritized_alarm_beeper.sv]
// ============================================================================
// prioritized_alarm_beeper : prioritised alarm buzzer controller
// Status requests in, buzzer commands out, with a battery EMA filter, an
// APB register file and a short queue between filter and sequencer.
// ============================================================================
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------
//  status    | in        | i_s_tvalid / o_s_tready        | i_s_tdata (status tick)
//  command   | out       | o_m_tvalid / i_m_tready        | o_m_tdata (buzzer cmd)
//  registers | in/out    | i_psel, i_penable, o_pready    | i_paddr, i_pwdata, o_prdata
//
//  One request per clock sustained while the output is not stalled; each request is
//  registered in the queue, then in the sequencer's output register, before its result shows.
//  The filter recurrence (one reciprocal multiply by 1/25) is combinational around the filter register.
//  A stalled output fills the two-entry queue, then o_s_tready drops.
//  Synchronous active-low reset; registers return to their defaults.
//
module prioritized_alarm_beeper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // status: [0] error_active, [16:1] battery_mv, [17] link_timed_out,
    //         [21:18] op_mode, [22] host_connected, [38:23] vision_age_ms
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pab_pkg::S_TDATA_W-1:0] i_s_tdata,
    // command: [1:0] action, [13:2] tone_hz, [16:14] alarm, [17] beeping,
    //          [33:18] filtered_mv
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pab_pkg::M_TDATA_W-1:0] o_m_tdata,
    // register port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [pab_pkg::CFG_AW-1:0]    i_paddr,
    input  logic [pab_pkg::CFG_DW-1:0]    i_pwdata,
    output logic [pab_pkg::CFG_DW-1:0]    o_prdata,
    output logic                          o_pready
);

    pab_pkg::t_cfg    r_cfg;
    pab_pkg::t_item   push_item;
    pab_pkg::t_item   head_item;
    pab_pkg::t_reg_idx reg_idx;
    logic             q_push;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    logic             wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = pab_pkg::t_reg_idx'(i_paddr[pab_pkg::CFG_AW-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lv_limit   <= 16'd22000;
            r_cfg.dbg_limit  <= 4'd3;
            r_cfg.vis_fresh  <= 16'd500;
            r_cfg.err_period <= 8'd20;
            r_cfg.lv_period  <= 8'd100;
            r_cfg.lnk_period <= 8'd200;
            r_cfg.vis_period <= 8'd20;
        end else if (wr_en) begin
            unique case (reg_idx)
                pab_pkg::REG_LV_LIMIT:   r_cfg.lv_limit   <= i_pwdata[15:0];
                pab_pkg::REG_DBG_LIMIT:  r_cfg.dbg_limit  <= i_pwdata[3:0];
                pab_pkg::REG_VIS_FRESH:  r_cfg.vis_fresh  <= i_pwdata[15:0];
                pab_pkg::REG_ERR_PERIOD: r_cfg.err_period <= i_pwdata[7:0];
                pab_pkg::REG_LV_PERIOD:  r_cfg.lv_period  <= i_pwdata[7:0];
                pab_pkg::REG_LNK_PERIOD: r_cfg.lnk_period <= i_pwdata[7:0];
                pab_pkg::REG_VIS_PERIOD: r_cfg.vis_period <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            pab_pkg::REG_LV_LIMIT:   o_prdata = 32'(r_cfg.lv_limit);
            pab_pkg::REG_DBG_LIMIT:  o_prdata = 32'(r_cfg.dbg_limit);
            pab_pkg::REG_VIS_FRESH:  o_prdata = 32'(r_cfg.vis_fresh);
            pab_pkg::REG_ERR_PERIOD: o_prdata = 32'(r_cfg.err_period);
            pab_pkg::REG_LV_PERIOD:  o_prdata = 32'(r_cfg.lv_period);
            pab_pkg::REG_LNK_PERIOD: o_prdata = 32'(r_cfg.lnk_period);
            pab_pkg::REG_VIS_PERIOD: o_prdata = 32'(r_cfg.vis_period);
            default:                 o_prdata = '0;
        endcase
    end

    pab_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_item     (push_item)
    );

    pab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    pab_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (q_empty),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[rtl/pab_checker.sv]
// ============================================================================
// pab_checker : port-level checks for the alarm beeper
// Watches the command stream for consistent action, tone, alarm and phase.
// ============================================================================
module pab_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [pab_pkg::M_TDATA_W-1:0] o_m_tdata
);

    logic [1:0]  act;
    logic [11:0] tone;
    logic [2:0]  alm;
    logic        beep;

    assign act  = o_m_tdata[pab_pkg::M_ACT_LSB  +: 2];
    assign tone = o_m_tdata[pab_pkg::M_TONE_LSB +: pab_pkg::TONE_W];
    assign alm  = o_m_tdata[pab_pkg::M_ALM_LSB  +: 3];
    assign beep = o_m_tdata[pab_pkg::M_BEEP_LSB];

    // a stalled command holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("command changed while stalled");

    // tone only with a start
    a_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && act != pab_pkg::ACT_START) |-> (tone == '0))
        else $error("tone without start");

    // a start leaves the phase on, a stop leaves it off
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && act != pab_pkg::ACT_NONE) |-> (beep == (act == pab_pkg::ACT_START)))
        else $error("phase disagrees with action");

    // no alarm never starts a tone nor keeps the phase on
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && alm == pab_pkg::ALM_NONE) |-> (act != pab_pkg::ACT_START && !beep))
        else $error("beep without alarm");

    // only the error tone and the alternating link and vision tones occur
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && act == pab_pkg::ACT_START) |->
        ((alm == pab_pkg::ALM_ERROR  && tone == pab_pkg::TONE_ERROR) ||
         (alm == pab_pkg::ALM_LINK   && (tone == pab_pkg::TONE_LINK_LO ||
                                         tone == pab_pkg::TONE_LINK_HI)) ||
         (alm == pab_pkg::ALM_VISION && (tone == pab_pkg::TONE_VIS_LO ||
                                         tone == pab_pkg::TONE_VIS_HI))))
        else $error("start with wrong tone");

endmodule

bind prioritized_alarm_beeper pab_checker u_pab_checker (.*);

[verif/tb_prioritized_alarm_beeper.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_prioritized_alarm_beeper : self-checking bench for the alarm beeper
// Drives status requests and register writes, predicts every buzzer command
// with a cycle-free model of the alarm priority, the battery filter and the
// beep sequencer, and compares each command field by field in order.
// ============================================================================
module tb_prioritized_alarm_beeper;

    localparam int         N_PHASES    = 11;
    localparam int         MAX_PHASE   = 2;
    localparam int         DRAIN_LIMIT = 2000;
    localparam logic [11:0] HZ_ERROR   = 12'd2200;
    localparam logic [11:0] HZ_LINK_LO = 12'd500;
    localparam logic [11:0] HZ_LINK_HI = 12'd561;
    localparam logic [11:0] HZ_VIS_LO  = 12'd2000;
    localparam logic [11:0] HZ_VIS_HI  = 12'd2244;
    localparam int         FRAC        = pab_pkg::FILT_FRAC_BITS;
    localparam int         SW          = pab_pkg::S_TDATA_W;
    localparam int         MW          = pab_pkg::M_TDATA_W;

    // kinds of status run used by the random part
    typedef enum int {
        SCN_ERROR, SCN_LOW_BATT, SCN_LINK, SCN_VISION, SCN_QUIET, SCN_NOISE
    } t_scn;

    typedef struct {
        pab_pkg::t_action act;
        logic [11:0]      tone;
        pab_pkg::t_alarm  alm;
        logic             beep;
        logic [15:0]      fmv;
    } t_beeper_cmd;

    // ------------------------------------------------------------------
    // Scoreboard: alarm predictor plus queue of expected commands
    // ------------------------------------------------------------------
    class beeper_scoreboard;
        logic [15:0]     lv_limit;
        logic [3:0]      dbg_limit;
        logic [15:0]     vis_fresh;
        logic [7:0]      err_period, lv_period, lnk_period, vis_period;
        logic [7:0]      ticks;
        logic            phase, hi_tone, vis_seen;
        longint unsigned filt;
        t_beeper_cmd     cmd_expected[$];
        int              n_fail;

        function new();
            lv_limit   = 16'd22000;
            dbg_limit  = 4'd3;
            vis_fresh  = 16'd500;
            err_period = 8'd20;
            lv_period  = 8'd100;
            lnk_period = 8'd200;
            vis_period = 8'd20;
            ticks      = '0;
            phase      = 1'b0;
            hi_tone    = 1'b0;
            vis_seen   = 1'b0;
            filt       = 64'd20000 << FRAC;
            n_fail     = 0;
        endfunction

        function void set_reg(pab_pkg::t_reg_idx idx, logic [31:0] v);
            case (idx)
                pab_pkg::REG_LV_LIMIT:   lv_limit   = v[15:0];
                pab_pkg::REG_DBG_LIMIT:  dbg_limit  = v[3:0];
                pab_pkg::REG_VIS_FRESH:  vis_fresh  = v[15:0];
                pab_pkg::REG_ERR_PERIOD: err_period = v[7:0];
                pab_pkg::REG_LV_PERIOD:  lv_period  = v[7:0];
                pab_pkg::REG_LNK_PERIOD: lnk_period = v[7:0];
                pab_pkg::REG_VIS_PERIOD: vis_period = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return cmd_expected.size();
        endfunction

        // one accepted status request -> one expected command
        function void note_status(logic [SW-1:0] w);
            logic        err, link, conn;
            logic [15:0] mv, age;
            logic [3:0]  mode;
            logic [7:0]  per;
            t_beeper_cmd c;
            err  = w[pab_pkg::S_ERR_LSB];
            mv   = w[pab_pkg::S_MV_LSB +: 16];
            link = w[pab_pkg::S_LINK_LSB];
            mode = w[pab_pkg::S_MODE_LSB +: 4];
            conn = w[pab_pkg::S_CONN_LSB];
            age  = w[pab_pkg::S_AGE_LSB +: 16];
            c.act  = pab_pkg::ACT_NONE;
            c.tone = '0;
            c.alm  = pab_pkg::ALM_NONE;
            per    = '0;
            if (ticks != 8'hFF) ticks = ticks + 8'd1;

            // priority chain; lower tests only run when higher ones are clear
            if (err) begin
                c.alm = pab_pkg::ALM_ERROR;
                per   = err_period;
            end else begin
                filt = (64'd99 * filt + (64'(mv) << FRAC) + 64'd50) / 64'd100;
                if (filt != 0 && filt < (64'(lv_limit) << FRAC)) begin
                    c.alm = pab_pkg::ALM_LOW_V;
                    per   = lv_period;
                end else if (link && mode <= dbg_limit) begin
                    c.alm = pab_pkg::ALM_LINK;
                    per   = lnk_period;
                end else if (conn) begin
                    if (age < vis_fresh) begin
                        vis_seen = 1'b1;
                    end else if (mode <= dbg_limit && vis_seen) begin
                        c.alm = pab_pkg::ALM_VISION;
                        per   = vis_period;
                    end
                end
            end

            // beep sequencer
            if (c.alm == pab_pkg::ALM_NONE) begin
                if (phase) begin
                    phase = 1'b0;
                    c.act = pab_pkg::ACT_STOP;
                end
            end else if (ticks > per) begin
                ticks = '0;
                if (!phase) begin
                    phase = 1'b1;
                    case (c.alm)
                        pab_pkg::ALM_ERROR: begin
                            c.act  = pab_pkg::ACT_START;
                            c.tone = HZ_ERROR;
                        end
                        pab_pkg::ALM_LINK: begin
                            c.act   = pab_pkg::ACT_START;
                            c.tone  = hi_tone ? HZ_LINK_HI : HZ_LINK_LO;
                            hi_tone = !hi_tone;
                        end
                        pab_pkg::ALM_VISION: begin
                            c.act   = pab_pkg::ACT_START;
                            c.tone  = hi_tone ? HZ_VIS_HI : HZ_VIS_LO;
                            hi_tone = !hi_tone;
                        end
                        default: ;  // low voltage toggles silently
                    endcase
                end else begin
                    phase = 1'b0;
                    c.act = pab_pkg::ACT_STOP;
                end
            end
            c.beep = phase;
            c.fmv  = 16'(filt >> FRAC);
            cmd_expected.push_back(c);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
            n_fail++;
        endtask

        task check_command(logic [MW-1:0] w);
            t_beeper_cmd c;
            if (cmd_expected.size() == 0) begin
                report("command with no request pending", 64'(w), 64'd0);
                return;
            end
            c = cmd_expected.pop_front();
            if (w[pab_pkg::M_ACT_LSB +: 2] !== c.act)
                report("action", 64'(w[pab_pkg::M_ACT_LSB +: 2]), 64'(c.act));
            if (w[pab_pkg::M_TONE_LSB +: 12] !== c.tone)
                report("tone_hz", 64'(w[pab_pkg::M_TONE_LSB +: 12]), 64'(c.tone));
            if (w[pab_pkg::M_ALM_LSB +: 3] !== c.alm)
                report("alarm", 64'(w[pab_pkg::M_ALM_LSB +: 3]), 64'(c.alm));
            if (w[pab_pkg::M_BEEP_LSB] !== c.beep)
                report("beeping", 64'(w[pab_pkg::M_BEEP_LSB]), 64'(c.beep));
            if (w[pab_pkg::M_FMV_LSB +: 16] !== c.fmv)
                report("filtered_mv", 64'(w[pab_pkg::M_FMV_LSB +: 16]), 64'(c.fmv));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [SW-1:0]                 i_s_tdata  = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [MW-1:0]                 o_m_tdata;
    logic                          i_psel     = 1'b0;
    logic                          i_penable  = 1'b0;
    logic                          i_pwrite   = 1'b0;
    logic [pab_pkg::CFG_AW-1:0]    i_paddr    = '0;
    logic [pab_pkg::CFG_DW-1:0]    i_pwdata   = '0;
    logic [pab_pkg::CFG_DW-1:0]    o_prdata;
    logic                          o_pready;

    beeper_scoreboard sb = new();
    bit idling     = 1'b1;
    int stall_left = 0;

    prioritized_alarm_beeper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // command side: check accepted commands, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_command(o_m_tdata);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= (stall_left == 1);
        end else if (idling && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    function automatic logic [SW-1:0] status_word(logic err, logic [15:0] mv,
            logic link, logic [3:0] mode, logic conn, logic [15:0] age);
        logic [SW-1:0] w;
        w = '0;
        w[pab_pkg::S_ERR_LSB]        = err;
        w[pab_pkg::S_MV_LSB +: 16]   = mv;
        w[pab_pkg::S_LINK_LSB]       = link;
        w[pab_pkg::S_MODE_LSB +: 4]  = mode;
        w[pab_pkg::S_CONN_LSB]       = conn;
        w[pab_pkg::S_AGE_LSB +: 16]  = age;
        return w;
    endfunction

    task automatic send_status(logic [SW-1:0] w);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_status(w);
    endtask

    // lower valid and let every outstanding command come back
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(pab_pkg::t_reg_idx idx, logic [31:0] v);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= v;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_reg(idx, v);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(int lv, int dbg, int fresh, int ep, int lp, int kp, int vp);
        write_reg(pab_pkg::REG_LV_LIMIT, lv);
        write_reg(pab_pkg::REG_DBG_LIMIT, dbg);
        write_reg(pab_pkg::REG_VIS_FRESH, fresh);
        write_reg(pab_pkg::REG_ERR_PERIOD, ep);
        write_reg(pab_pkg::REG_LV_PERIOD, lp);
        write_reg(pab_pkg::REG_LNK_PERIOD, kp);
        write_reg(pab_pkg::REG_VIS_PERIOD, vp);
    endtask

    function automatic int rand_period();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 12);
    endfunction

    // per-phase register setting: reset values, all minimums, limits at maximum with periods just below it, then random
    task automatic pick_setting(int p);
        int lv;
        if (p == 0) begin
            program_regs(22000, 3, 500, 20, 100, 200, 20);
        end else if (p == 1) begin
            program_regs(0, 0, 0, 0, 0, 0, 0);
        end else if (p == MAX_PHASE) begin
            program_regs(65535, 15, 65535, 254, 254, 254, 254);
        end else begin
            // limit near the present filter level so that low battery comes and goes
            lv = int'(sb.filt >> FRAC) + int'($urandom_range(0, 800)) - 400;
            if (lv < 0) lv = 0;
            if (lv > 65535) lv = 65535;
            if ($urandom_range(0, 3) == 0) lv = 0;
            program_regs(lv, $urandom_range(0, 15),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(1, 3000),
                         rand_period(), rand_period(), rand_period(), rand_period());
        end
    endtask

    // one status request shaped to provoke the given alarm
    function automatic logic [SW-1:0] random_status(t_scn scn);
        int          lv, lo, hi, dbg, fresh;
        logic        err, link, conn;
        logic [15:0] mv, age;
        logic [3:0]  mode;
        lv    = int'(sb.lv_limit);
        dbg   = int'(sb.dbg_limit);
        fresh = int'(sb.vis_fresh);
        lo    = (lv > 3000) ? lv - 3000 : 0;
        hi    = (lv < 62535) ? lv + 3000 : 65535;
        err   = 1'b0;
        link  = 1'b0;
        conn  = 1'($urandom_range(0, 1));
        mv    = 16'($urandom_range(lv, hi));
        mode  = 4'($urandom_range(0, dbg));
        age   = 16'($urandom);
        if ($urandom_range(0, 9) == 0) scn = SCN_NOISE;
        case (scn)
            SCN_ERROR: begin
                err  = 1'b1;
                mv   = 16'($urandom);
                link = 1'($urandom_range(0, 1));
                mode = 4'($urandom);
            end
            SCN_LOW_BATT: begin
                mv   = 16'($urandom_range(lo, lv));
                link = 1'($urandom_range(0, 1));
            end
            SCN_LINK: link = 1'b1;
            SCN_VISION: begin
                conn = 1'b1;
                if ($urandom_range(0, 7) == 0 && fresh > 0)
                    age = 16'($urandom_range(0, fresh - 1));
                else
                    age = 16'($urandom_range(fresh, 65535));
            end
            SCN_QUIET: begin
                if (fresh > 0) age = 16'($urandom_range(0, fresh - 1));
                else conn = 1'b0;
            end
            default: begin
                err  = 1'($urandom_range(0, 1));
                mv   = 16'($urandom);
                link = 1'($urandom_range(0, 1));
                mode = 4'($urandom);
                conn = 1'($urandom_range(0, 1));
            end
        endcase
        return status_word(err, mv, link, mode, conn, age);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int   p, n, len;
        t_scn scn;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset setting, all-zero and all-one requests
        send_status(status_word(1'b0, 16'h0000, 1'b0, 4'h0, 1'b0, 16'h0000));
        send_status(status_word(1'b1, 16'hFFFF, 1'b1, 4'hF, 1'b1, 16'hFFFF));
        wait_idle();
        program_regs(0, 15, 500, 0, 1, 0, 2);
        // error tone on and off, then link pre-empting a running beep
        repeat (3) send_status(status_word(1'b1, 16'd1234, 1'b1, 4'h2, 1'b1, 16'd9));
        repeat (4) send_status(status_word(1'b0, 16'hFFFF, 1'b1, 4'hF, 1'b0, 16'd0));
        // no alarm while the beep is on stops it
        send_status(status_word(1'b0, 16'd30000, 1'b0, 4'h7, 1'b0, 16'd0));
        // a fresh frame arms the vision alarm, then vision is lost
        send_status(status_word(1'b0, 16'd30000, 1'b0, 4'h0, 1'b1, 16'd0));
        send_status(status_word(1'b0, 16'd30000, 1'b0, 4'h0, 1'b1, 16'd499));
        repeat (5) send_status(status_word(1'b0, 16'd30000, 1'b0, 4'hF, 1'b1, 16'hFFFF));
        send_status(status_word(1'b0, 16'd30000, 1'b0, 4'h0, 1'b1, 16'd500));
        wait_idle();
        // low voltage: silent start, audible stop
        write_reg(pab_pkg::REG_LV_LIMIT, 65535);
        repeat (5) send_status(status_word(1'b0, 16'h0000, 1'b0, 4'h0, 1'b0, 16'h0000));

        // random phases; the last two run without idling
        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            pick_setting(p);
            idling = (p < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            n = (p == MAX_PHASE) ? 320 : 100;
            while (n > 0) begin
                scn = t_scn'($urandom_range(0, 5));
                len = $urandom_range(1, 30);
                repeat (len) if (n > 0) begin
                    send_status(random_status(scn));
                    n--;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("PASS prioritized_alarm_beeper");
        end else begin
            $display("FAIL prioritized_alarm_beeper");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("FAIL prioritized_alarm_beeper");
        $finish;
    end

endmodule

[files.f]
rtl/pab_pkg.sv
rtl/pab_front.sv
rtl/pab_queue.sv
rtl/pab_back.sv
rtl/prioritized_alarm_beeper.sv
rtl/pab_checker.sv
verif/tb_prioritized_alarm_beeper.sv
